[hw/rtl/olb_pkg.sv]
// olb_pkg: shared types and codes for the order-log book builder
// memory word layouts, event kinds, status codes, register indexes, alu ops
// no dependencies
package olb_pkg;

  localparam int ALU_W = 42;

  localparam logic [39:0] VOL_CAP = 40'hFF_FFFF_FFFF;
  localparam logic [15:0] ORD_CAP = 16'hFFFF;

  // shared arithmetic unit
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic signed [ALU_W-1:0] sum;
    logic                    le_zero;
    logic                    lt_zero;
  } alu_res_t;

  // order slot word
  typedef struct packed {
    logic               used;
    logic [63:0]        key;
    logic               side;
    logic signed [31:0] price;
    logic [31:0]        amount;
  } slot_word_t;

  // price level word
  typedef struct packed {
    logic signed [31:0] price;
    logic [39:0]        volume;
    logic [15:0]        orders;
  } level_word_t;

  // event kinds
  localparam logic [2:0] KIND_ADD    = 3'd0;
  localparam logic [2:0] KIND_FILL   = 3'd1;
  localparam logic [2:0] KIND_MOVE   = 3'd2;
  localparam logic [2:0] KIND_CANCEL = 3'd3;
  localparam logic [2:0] KIND_REMOVE = 3'd4;

  // side codes
  localparam logic [1:0] SIDE_UNKNOWN = 2'd0;
  localparam logic [1:0] SIDE_SELL    = 2'd2;
  localparam logic [1:0] SIDE_BAD     = 2'd3;

  // orphan fill modes
  localparam logic [1:0] OFM_MISSING = 2'd0;
  localparam logic [1:0] OFM_REDUCE  = 2'd2;

  // status codes
  localparam logic [3:0] STAT_APPLIED  = 4'd0;
  localparam logic [3:0] STAT_SKIPPED  = 4'd1;
  localparam logic [3:0] STAT_BAD_SIDE = 4'd2;
  localparam logic [3:0] STAT_ZERO_AMT = 4'd3;
  localparam logic [3:0] STAT_MISSING  = 4'd4;
  localparam logic [3:0] STAT_ORPHAN   = 4'd5;
  localparam logic [3:0] STAT_REDUCED  = 4'd6;
  localparam logic [3:0] STAT_MISMATCH = 4'd7;
  localparam logic [3:0] STAT_NO_LEVEL = 4'd8;
  localparam logic [3:0] STAT_CLAMPED  = 4'd9;
  localparam logic [3:0] STAT_FULL     = 4'd10;
  localparam logic [3:0] STAT_OTHER    = 4'd11;

  // configuration register indexes
  localparam logic [2:0] CFG_COUNTER_SKIP    = 3'd0;
  localparam logic [2:0] CFG_NON_SYSTEM_SKIP = 3'd1;
  localparam logic [2:0] CFG_QUOTE_SKIP      = 3'd2;
  localparam logic [2:0] CFG_ORPHAN_FILL     = 3'd3;
  localparam logic [2:0] CFG_ORPHAN_CANCEL   = 3'd4;
  localparam logic [2:0] CFG_FILL_DELTA      = 3'd5;

endpackage

[hw/rtl/olb_ram.sv]
// olb_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module olb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/olb_alu.sv]
// olb_alu: shared 42-bit add/subtract unit with sign and zero flags
// depends on olb_pkg
module olb_alu (
  input  olb_pkg::alu_op_t                   op,
  input  logic signed [olb_pkg::ALU_W-1:0]   a,
  input  logic signed [olb_pkg::ALU_W-1:0]   b,
  output olb_pkg::alu_res_t                  res
);

  logic signed [olb_pkg::ALU_W-1:0] sum;

  // add or subtract, then flags
  always_comb begin
    sum = (op == olb_pkg::ALU_ADD) ? (a + b) : (a - b);
    res.sum     = sum;
    res.lt_zero = sum[olb_pkg::ALU_W-1];
    res.le_zero = sum[olb_pkg::ALU_W-1] | (sum == '0);
  end

endmodule

[hw/rtl/order_log_book_builder.sv]
// order_log_book_builder: top level, event sequencer, order and level tables
// depends on olb_pkg, olb_ram, olb_alu
//
// channel   dir  handshake                word
// s_axis    in   s_axis_tvalid/tready     one order-log event
// m_axis    out  m_axis_tvalid/tready     status and best bid/ask
// cfg       in   cfg_valid/cfg_ready      register index and data
//
// an event that passes the input checks walks the slot table once through the
// slot memory read port, one side of the level table once per level lookup (a
// move walks one side twice) and the whole level table once for best prices.
// after reset a clearing pass over all ORDER_SLOTS slots runs before the
// first word is taken. a result waiting on m_axis does not block the next
// input word; the block stalls only at the end of the following event.
module order_log_book_builder #(
  parameter int ORDER_SLOTS     = 1024,
  parameter int LEVELS_PER_SIDE = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [63:0] order_key, [65:64] side_code, [97:66] price_value,
  // [129:98] amount_total, [161:130] amount_left
  input  logic [167:0] s_axis_tdata,
  // [2:0] kind, [3] flag_counter, [4] flag_non_system, [5] flag_quote
  input  logic [7:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [0] bid_present, [32:1] best_bid_price, [72:33] best_bid_qty,
  // [73] ask_present, [105:74] best_ask_price, [145:106] best_ask_qty,
  // [146] book_crossed
  output logic [151:0] m_axis_tdata,
  // [3:0] status
  output logic [7:0]   m_axis_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [1:0]   cfg_data
);

  localparam int SW       = $clog2(ORDER_SLOTS);
  localparam int NL       = 2 * LEVELS_PER_SIDE;
  localparam int LW       = $clog2(NL);
  localparam int SCAN_MAX = (ORDER_SLOTS > NL) ? ORDER_SLOTS : NL;
  localparam int CW       = $clog2(SCAN_MAX + 1);
  localparam int AW       = olb_pkg::ALU_W;

  typedef enum logic [8:0] {
    ST_CLEAR    = 9'b000000001,
    ST_IDLE     = 9'b000000010,
    ST_PREP     = 9'b000000100,
    ST_SSCAN    = 9'b000001000,
    ST_DISPATCH = 9'b000010000,
    ST_LSCAN    = 9'b000100000,
    ST_LAPPLY   = 9'b001000000,
    ST_BSCAN    = 9'b010000000,
    ST_DONE     = 9'b100000000
  } state_t;

  // purpose of the current level lookup
  typedef enum logic [2:0] {
    LP_ADD,
    LP_OREDUCE,
    LP_FILL,
    LP_MREL,
    LP_MGET,
    LP_PCAN,
    LP_REL
  } lphase_t;

  state_t  state;
  lphase_t phase;

  // configuration
  logic       cfg_counter_skip, cfg_non_system_skip, cfg_quote_skip;
  logic [1:0] cfg_orphan_fill;
  logic       cfg_orphan_cancel, cfg_fill_delta;

  // latched event
  logic [2:0]         ev_kind;
  logic [63:0]        ev_key;
  logic [1:0]         ev_sc;
  logic signed [31:0] ev_price;
  logic [31:0]        ev_total, ev_left;

  // scan pipeline
  logic [CW-1:0] cnt;
  logic [CW-1:0] scan_lim;
  logic          rd_v, rd_last, rd_used, rd_ask;
  logic [SW-1:0] rd_sidx;
  logic [LW-1:0] rd_lidx;

  // slot lookup results
  logic                s_found, f_found;
  logic [SW-1:0]       s_idx, f_idx;
  olb_pkg::slot_word_t hold;
  logic signed [AW-1:0] fill_r;

  // level lookup results
  logic                 tgt_side;
  logic signed [31:0]   tgt_price;
  logic                 lmatch, lfree;
  logic [LW-1:0]        lm_idx, lf_idx;
  olb_pkg::level_word_t lm_word;
  logic signed [AW-1:0] opnd;
  logic                 full_r, rel_found;
  logic [3:0]           st_r;
  logic [NL-1:0]        lused;

  // best prices
  logic               bp, ap;
  logic signed [31:0] bpx, apx;
  logic [39:0]        bq, aq;

  // output register
  logic         out_valid;
  logic [151:0] out_data;
  logic [3:0]   out_status;

  // memories and alu
  logic                 slot_we, lvl_we;
  logic [SW-1:0]        slot_waddr, slot_raddr;
  logic [LW-1:0]        lvl_waddr, lvl_raddr, lscan_base;
  olb_pkg::slot_word_t  slot_wdata, slot_rdata;
  olb_pkg::level_word_t lvl_wdata, lvl_rdata;
  olb_pkg::alu_op_t     alu_op;
  logic signed [AW-1:0] alu_a, alu_b;
  olb_pkg::alu_res_t    alu_res;

  // level apply decisions
  logic          ap_set, ap_clr;
  logic [LW-1:0] ap_idx;
  logic [3:0]    ap_st;
  logic [15:0]   base_ord;
  logic [31:0]   amt_new;
  logic          side_bad, skip_hit;

  olb_ram #(
    .WIDTH ($bits(olb_pkg::slot_word_t)),
    .DEPTH (ORDER_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  olb_ram #(
    .WIDTH ($bits(olb_pkg::level_word_t)),
    .DEPTH (NL)
  ) u_level_ram (
    .clk   (clk),
    .we    (lvl_we),
    .waddr (lvl_waddr),
    .wdata (lvl_wdata),
    .raddr (lvl_raddr),
    .rdata (lvl_rdata)
  );

  olb_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = {4'b0, out_status};

  assign amt_new  = (ev_left != '0) ? ev_left : hold.amount;
  assign side_bad = (ev_sc == olb_pkg::SIDE_UNKNOWN) || (ev_sc == olb_pkg::SIDE_BAD);
  assign skip_hit = (s_axis_tuser[3] & cfg_counter_skip) |
                    (s_axis_tuser[4] & cfg_non_system_skip) |
                    (s_axis_tuser[5] & cfg_quote_skip);

  // scan addressing
  always_comb begin
    lscan_base = '0;
    scan_lim   = CW'(NL);
    if (state == ST_LSCAN) begin
      lscan_base = tgt_side ? LW'(LEVELS_PER_SIDE) : '0;
      scan_lim   = CW'(LEVELS_PER_SIDE);
    end else if (state == ST_SSCAN) begin
      scan_lim   = CW'(ORDER_SLOTS);
    end
    lvl_raddr  = lscan_base + cnt[LW-1:0];
    slot_raddr = cnt[SW-1:0];
  end

  // alu operands, memory writes and level apply decisions
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = s_idx;
    slot_wdata = hold;
    lvl_we     = 1'b0;
    lvl_waddr  = lm_idx;
    lvl_wdata  = lm_word;
    alu_op     = olb_pkg::ALU_SUB;
    alu_a      = {10'b0, hold.amount};
    alu_b      = opnd;
    ap_set     = 1'b0;
    ap_clr     = 1'b0;
    ap_idx     = lm_idx;
    ap_st      = olb_pkg::STAT_APPLIED;
    base_ord   = lmatch ? lm_word.orders : '0;
    case (state)
      ST_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = cnt[SW-1:0];
        slot_wdata = '0;
      end
      ST_PREP: begin
        alu_a = {10'b0, ev_total};
        alu_b = {10'b0, ev_left};
      end
      ST_DISPATCH: begin
        alu_b = (ev_kind == olb_pkg::KIND_FILL) ? fill_r : {10'b0, ev_left};
        if (s_found) begin
          if (ev_kind == olb_pkg::KIND_FILL) begin
            if (!fill_r[AW-1]) begin
              slot_we           = 1'b1;
              slot_wdata.used   = ~alu_res.le_zero;
              slot_wdata.amount = alu_res.sum[31:0];
            end
          end else if (ev_kind == olb_pkg::KIND_CANCEL && ev_left != '0) begin
            if (!alu_res.lt_zero) begin
              slot_we           = 1'b1;
              slot_wdata.amount = ev_left;
            end
          end else if (ev_kind != olb_pkg::KIND_MOVE && ev_kind != olb_pkg::KIND_ADD) begin
            slot_we         = 1'b1;
            slot_wdata.used = 1'b0;
          end
        end
      end
      ST_LAPPLY: begin
        alu_a = {2'b0, lm_word.volume};
        case (phase)
          LP_ADD, LP_MGET: begin
            alu_op = olb_pkg::ALU_ADD;
            if (!lmatch) begin
              alu_a = '0;
            end
            lvl_wdata.price  = tgt_price;
            lvl_wdata.volume = (alu_res.sum[AW-1:40] != '0) ? olb_pkg::VOL_CAP
                                                              : alu_res.sum[39:0];
            lvl_wdata.orders = (base_ord == olb_pkg::ORD_CAP) ? base_ord
                                                              : base_ord + 16'd1;
            ap_idx    = lmatch ? lm_idx : lf_idx;
            lvl_waddr = ap_idx;
            if (phase == LP_ADD) begin
              slot_waddr = s_found ? s_idx : f_idx;
              slot_wdata = '{used: 1'b1, key: ev_key, side: (ev_sc == olb_pkg::SIDE_SELL),
                             price: ev_price, amount: ev_left};
              if (lmatch || lfree) begin
                lvl_we  = 1'b1;
                slot_we = 1'b1;
                ap_set  = 1'b1;
              end else begin
                ap_st = olb_pkg::STAT_FULL;
              end
            end else begin
              slot_we = 1'b1;
              if (lmatch || lfree) begin
                lvl_we            = 1'b1;
                ap_set            = 1'b1;
                slot_wdata.price  = ev_price;
                slot_wdata.amount = amt_new;
                ap_st = rel_found ? olb_pkg::STAT_APPLIED : olb_pkg::STAT_NO_LEVEL;
              end else begin
                slot_wdata.used = 1'b0;
                ap_st           = olb_pkg::STAT_FULL;
              end
            end
          end
          LP_OREDUCE: begin
            lvl_wdata.volume = alu_res.sum[39:0];
            if (lmatch) begin
              ap_st  = olb_pkg::STAT_REDUCED;
              ap_clr = alu_res.le_zero;
              lvl_we = ~alu_res.le_zero;
            end else begin
              ap_st = olb_pkg::STAT_ORPHAN;
            end
          end
          LP_FILL: begin
            lvl_wdata.volume = alu_res.sum[39:0];
            if (full_r && lm_word.orders != '0) begin
              lvl_wdata.orders = lm_word.orders - 16'd1;
            end
            if (lmatch) begin
              ap_clr = alu_res.le_zero;
              lvl_we = ~alu_res.le_zero;
            end else begin
              ap_st = olb_pkg::STAT_NO_LEVEL;
            end
          end
          LP_MREL, LP_REL: begin
            lvl_wdata.volume = alu_res.sum[39:0];
            lvl_wdata.orders = lm_word.orders - 16'd1;
            if (lmatch) begin
              if (lm_word.orders <= 16'd1 || alu_res.le_zero) begin
                ap_clr = 1'b1;
              end else begin
                lvl_we = 1'b1;
              end
            end else begin
              ap_st = olb_pkg::STAT_NO_LEVEL;
            end
          end
          LP_PCAN: begin
            lvl_wdata.volume = alu_res.lt_zero ? '0 : alu_res.sum[39:0];
            if (lmatch) begin
              lvl_we = 1'b1;
              ap_st  = alu_res.lt_zero ? olb_pkg::STAT_CLAMPED : olb_pkg::STAT_APPLIED;
            end else begin
              ap_st = olb_pkg::STAT_NO_LEVEL;
            end
          end
          default: begin
            ap_st = olb_pkg::STAT_APPLIED;
          end
        endcase
      end
      default: begin
        slot_we = 1'b0;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_counter_skip    <= 1'b0;
      cfg_non_system_skip <= 1'b0;
      cfg_quote_skip      <= 1'b0;
      cfg_orphan_fill     <= 2'd0;
      cfg_orphan_cancel   <= 1'b0;
      cfg_fill_delta      <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        olb_pkg::CFG_COUNTER_SKIP:    cfg_counter_skip    <= cfg_data[0];
        olb_pkg::CFG_NON_SYSTEM_SKIP: cfg_non_system_skip <= cfg_data[0];
        olb_pkg::CFG_QUOTE_SKIP:      cfg_quote_skip      <= cfg_data[0];
        olb_pkg::CFG_ORPHAN_FILL:     cfg_orphan_fill     <= cfg_data;
        olb_pkg::CFG_ORPHAN_CANCEL:   cfg_orphan_cancel   <= cfg_data[0];
        olb_pkg::CFG_FILL_DELTA:      cfg_fill_delta      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // event sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= '0;
      rd_v      <= 1'b0;
      out_valid <= 1'b0;
      lused     <= '0;
    end else begin
      if (m_axis_tready) begin
        out_valid <= 1'b0;
      end

      // shared read pipeline for all walks
      if (state == ST_SSCAN || state == ST_LSCAN || state == ST_BSCAN) begin
        if (cnt < scan_lim) begin
          cnt     <= cnt + 1'b1;
          rd_v    <= 1'b1;
          rd_last <= (cnt == scan_lim - 1'b1);
          rd_sidx <= cnt[SW-1:0];
          rd_lidx <= lvl_raddr;
          rd_used <= lused[lvl_raddr];
          rd_ask  <= (cnt >= CW'(LEVELS_PER_SIDE));
        end else begin
          rd_v <= 1'b0;
        end
      end

      case (state)
        ST_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == CW'(ORDER_SLOTS - 1)) begin
            cnt   <= '0;
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (s_axis_tvalid) begin
            ev_kind  <= s_axis_tuser[2:0];
            ev_key   <= s_axis_tdata[63:0];
            ev_sc    <= s_axis_tdata[65:64];
            ev_price <= s_axis_tdata[97:66];
            ev_total <= s_axis_tdata[129:98];
            ev_left  <= s_axis_tdata[161:130];
            cnt      <= '0;
            rd_v     <= 1'b0;
            bp       <= 1'b0;
            ap       <= 1'b0;
            bpx      <= '0;
            apx      <= '0;
            bq       <= '0;
            aq       <= '0;
            if (skip_hit) begin
              st_r  <= olb_pkg::STAT_SKIPPED;
              state <= ST_BSCAN;
            end else if (s_axis_tuser[2:0] > olb_pkg::KIND_REMOVE) begin
              st_r  <= olb_pkg::STAT_OTHER;
              state <= ST_BSCAN;
            end else if (s_axis_tuser[2:0] == olb_pkg::KIND_ADD &&
                         (s_axis_tdata[65:64] == olb_pkg::SIDE_UNKNOWN ||
                          s_axis_tdata[65:64] == olb_pkg::SIDE_BAD)) begin
              st_r  <= olb_pkg::STAT_BAD_SIDE;
              state <= ST_BSCAN;
            end else if (s_axis_tuser[2:0] == olb_pkg::KIND_ADD &&
                         s_axis_tdata[161:130] == '0) begin
              st_r  <= olb_pkg::STAT_ZERO_AMT;
              state <= ST_BSCAN;
            end else begin
              state <= ST_PREP;
            end
          end
        end

        // fill quantity through the alu
        ST_PREP: begin
          fill_r  <= cfg_fill_delta ? {10'b0, ev_total} : alu_res.sum;
          s_found <= 1'b0;
          f_found <= 1'b0;
          state   <= ST_SSCAN;
        end

        // walk the slot table: first holder of the key and first free slot
        ST_SSCAN: begin
          if (rd_v) begin
            if (slot_rdata.used && slot_rdata.key == ev_key && !s_found) begin
              s_found <= 1'b1;
              s_idx   <= rd_sidx;
              hold    <= slot_rdata;
            end
            if (!slot_rdata.used && !f_found) begin
              f_found <= 1'b1;
              f_idx   <= rd_sidx;
            end
            if (rd_last) begin
              cnt   <= '0;
              rd_v  <= 1'b0;
              state <= ST_DISPATCH;
            end
          end
        end

        ST_DISPATCH: begin
          cnt       <= '0;
          rd_v      <= 1'b0;
          lmatch    <= 1'b0;
          lfree     <= 1'b0;
          tgt_side  <= hold.side;
          tgt_price <= hold.price;
          opnd      <= {10'b0, hold.amount};
          state     <= ST_LSCAN;
          case (ev_kind)
            olb_pkg::KIND_ADD: begin
              tgt_side  <= (ev_sc == olb_pkg::SIDE_SELL);
              tgt_price <= ev_price;
              opnd      <= {10'b0, ev_left};
              phase     <= LP_ADD;
              if (!s_found && !f_found) begin
                st_r  <= olb_pkg::STAT_FULL;
                state <= ST_BSCAN;
              end
            end
            olb_pkg::KIND_FILL: begin
              if (!s_found) begin
                tgt_side  <= (ev_sc == olb_pkg::SIDE_SELL);
                tgt_price <= ev_price;
                opnd      <= fill_r;
                phase     <= LP_OREDUCE;
                if (cfg_orphan_fill == olb_pkg::OFM_MISSING) begin
                  st_r  <= olb_pkg::STAT_MISSING;
                  state <= ST_BSCAN;
                end else if (cfg_orphan_fill != olb_pkg::OFM_REDUCE ||
                             fill_r[AW-1] || fill_r == '0 || side_bad) begin
                  st_r  <= olb_pkg::STAT_ORPHAN;
                  state <= ST_BSCAN;
                end
              end else if (fill_r[AW-1]) begin
                st_r  <= olb_pkg::STAT_MISMATCH;
                state <= ST_BSCAN;
              end else begin
                full_r <= alu_res.le_zero;
                opnd   <= alu_res.le_zero ? {10'b0, hold.amount} : fill_r;
                phase  <= LP_FILL;
              end
            end
            olb_pkg::KIND_MOVE: begin
              phase <= LP_MREL;
              if (!s_found) begin
                st_r  <= olb_pkg::STAT_MISSING;
                state <= ST_BSCAN;
              end
            end
            default: begin
              if (!s_found) begin
                st_r  <= cfg_orphan_cancel ? olb_pkg::STAT_ORPHAN : olb_pkg::STAT_MISSING;
                state <= ST_BSCAN;
              end else if (ev_kind == olb_pkg::KIND_CANCEL && ev_left != '0) begin
                opnd  <= alu_res.sum;
                phase <= LP_PCAN;
                if (alu_res.lt_zero) begin
                  st_r  <= olb_pkg::STAT_MISMATCH;
                  state <= ST_BSCAN;
                end
              end else begin
                phase <= LP_REL;
              end
            end
          endcase
        end

        // walk one side of the level table: matching price and first free
        ST_LSCAN: begin
          if (rd_v) begin
            if (rd_used && lvl_rdata.price == tgt_price && !lmatch) begin
              lmatch  <= 1'b1;
              lm_idx  <= rd_lidx;
              lm_word <= lvl_rdata;
            end
            if (!rd_used && !lfree) begin
              lfree  <= 1'b1;
              lf_idx <= rd_lidx;
            end
            if (rd_last) begin
              cnt   <= '0;
              rd_v  <= 1'b0;
              state <= ST_LAPPLY;
            end
          end
        end

        ST_LAPPLY: begin
          if (ap_set) begin
            lused[ap_idx] <= 1'b1;
          end
          if (ap_clr) begin
            lused[ap_idx] <= 1'b0;
          end
          st_r  <= ap_st;
          cnt   <= '0;
          rd_v  <= 1'b0;
          state <= ST_BSCAN;
          if (phase == LP_MREL) begin
            rel_found <= lmatch;
            tgt_price <= ev_price;
            opnd      <= {10'b0, amt_new};
            lmatch    <= 1'b0;
            lfree     <= 1'b0;
            phase     <= LP_MGET;
            state     <= ST_LSCAN;
          end
        end

        // walk all levels for best bid and best ask
        ST_BSCAN: begin
          if (rd_v) begin
            if (rd_used && !rd_ask && (!bp || $signed(lvl_rdata.price) > bpx)) begin
              bp  <= 1'b1;
              bpx <= lvl_rdata.price;
              bq  <= lvl_rdata.volume;
            end
            if (rd_used && rd_ask && (!ap || $signed(lvl_rdata.price) < apx)) begin
              ap  <= 1'b1;
              apx <= lvl_rdata.price;
              aq  <= lvl_rdata.volume;
            end
            if (rd_last) begin
              cnt   <= '0;
              rd_v  <= 1'b0;
              state <= ST_DONE;
            end
          end
        end

        ST_DONE: begin
          if (!out_valid || m_axis_tready) begin
            out_valid  <= 1'b1;
            out_status <= st_r;
            out_data   <= {5'b0, (bp && ap && (bpx >= apx)), aq, apx, ap, bq, bpx, bp};
            state      <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // no input taken during the clearing pass
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !s_axis_tready)
    else $error("input taken during clearing pass");

  // an accepted word starts a multi-cycle event
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("ready held after accept");

  // status stays within the defined codes
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser[3:0] <= olb_pkg::STAT_OTHER))
    else $error("status code out of range");

  // a crossed book needs both sides
  a_crossed_sides: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[146]) |-> (m_axis_tdata[0] && m_axis_tdata[73]))
    else $error("crossed flag without both sides");

endmodule

[tb/tb_order_log_book_builder.sv]
// tb_order_log_book_builder: self-checking testbench for the order-log book builder
// drives events and register writes, predicts status and best prices, checks results
// depends on olb_pkg and order_log_book_builder
`timescale 1ns / 100ps

module tb_order_log_book_builder;
  import olb_pkg::*;

  localparam int NSLOT = 1024;
  localparam int NSIDE = 64;
  localparam longint VOL_MAX = 64'hFF_FFFF_FFFF;
  localparam int LIMIT_CYCLES = 12_000_000;
  localparam int SETTLE_CYCLES = 2000;

  typedef struct packed {
    logic [2:0]         kind;
    logic [63:0]        key;
    logic [1:0]         side;
    logic signed [31:0] price;
    logic [31:0]        total;
    logic [31:0]        left;
    logic               f_counter;
    logic               f_non_system;
    logic               f_quote;
  } book_event_t;

  typedef struct packed {
    logic [3:0]         status;
    logic               bid_p;
    logic signed [31:0] bid_px;
    logic [39:0]        bid_q;
    logic               ask_p;
    logic signed [31:0] ask_px;
    logic [39:0]        ask_q;
    logic               crossed;
  } book_top_t;

  logic         clk, rst;
  logic         s_axis_tvalid, s_axis_tready;
  logic [167:0] s_axis_tdata;
  logic [7:0]   s_axis_tuser;
  logic         m_axis_tvalid, m_axis_tready;
  logic [151:0] m_axis_tdata;
  logic [7:0]   m_axis_tuser;
  logic         cfg_valid, cfg_ready;
  logic [2:0]   cfg_index;
  logic [1:0]   cfg_data;

  order_log_book_builder DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of registers and tables
  bit         m_counter_skip, m_nonsys_skip, m_quote_skip, m_cancel_ignore, m_fill_delta;
  logic [1:0] m_fill_mode;
  bit         sl_used [NSLOT];
  logic [63:0] sl_key [NSLOT];
  bit         sl_side [NSLOT];
  longint     sl_price [NSLOT];
  longint     sl_amt [NSLOT];
  bit         lv_used [2*NSIDE];
  longint     lv_price [2*NSIDE];
  longint     lv_vol [2*NSIDE];
  int unsigned lv_orders [2*NSIDE];

  book_event_t event_backlog[$];
  book_top_t   book_expected[$];
  logic [63:0] live_keys[$];
  book_event_t cur_event;

  int send_idle_pct, recv_stall_pct;
  int mismatches, results_seen, cycles, hold_left;
  bit hold_done;

  // clock and cycle limit
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               book_expected.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int find_order(logic [63:0] key);
    for (int i = 0; i < NSLOT; i++)
      if (sl_used[i] && sl_key[i] == key) return i;
    return -1;
  endfunction

  function automatic int find_price_level(int sd, longint px);
    for (int i = sd * NSIDE; i < (sd + 1) * NSIDE; i++)
      if (lv_used[i] && lv_price[i] == px) return i;
    return -1;
  endfunction

  function automatic int claim_level(int sd, longint px);
    int i;
    i = find_price_level(sd, px);
    if (i >= 0) return i;
    for (i = sd * NSIDE; i < (sd + 1) * NSIDE; i++)
      if (!lv_used[i]) begin
        lv_used[i] = 1; lv_price[i] = px; lv_vol[i] = 0; lv_orders[i] = 0;
        return i;
      end
    return -1;
  endfunction

  function automatic void level_join(int lv, longint amt);
    longint v;
    v = lv_vol[lv] + amt;
    lv_vol[lv] = (v > VOL_MAX) ? VOL_MAX : v;
    if (lv_orders[lv] < 65535) lv_orders[lv]++;
  endfunction

  function automatic bit level_leave(int sd, longint px, longint amt);
    int lv;
    lv = find_price_level(sd, px);
    if (lv < 0) return 0;
    lv_vol[lv] -= amt;
    if (lv_orders[lv] <= 1 || lv_vol[lv] <= 0) lv_used[lv] = 0;
    else lv_orders[lv]--;
    return 1;
  endfunction

  // book update for one event, returns the status code
  function automatic logic [3:0] apply_book_event(book_event_t e);
    int s, lv, sd;
    longint px, tot, lft, fq, amt, diff;
    bit full, found;
    logic [3:0] st;
    px = e.price; tot = e.total; lft = e.left;
    if (e.f_counter && m_counter_skip) return STAT_SKIPPED;
    if (e.f_non_system && m_nonsys_skip) return STAT_SKIPPED;
    if (e.f_quote && m_quote_skip) return STAT_SKIPPED;
    if (e.kind > KIND_REMOVE) return STAT_OTHER;
    fq = m_fill_delta ? tot : tot - lft;
    s = find_order(e.key);
    if (e.kind == KIND_ADD) begin
      if (e.side == SIDE_UNKNOWN || e.side == SIDE_BAD) return STAT_BAD_SIDE;
      if (lft == 0) return STAT_ZERO_AMT;
      sd = (e.side == SIDE_SELL);
      if (s < 0) begin
        for (int i = 0; i < NSLOT; i++)
          if (!sl_used[i]) begin s = i; break; end
      end
      if (s < 0) return STAT_FULL;
      lv = claim_level(sd, px);
      if (lv < 0) return STAT_FULL;
      sl_used[s] = 1; sl_key[s] = e.key; sl_side[s] = sd;
      sl_price[s] = px; sl_amt[s] = lft;
      level_join(lv, lft);
      return STAT_APPLIED;
    end
    // unknown id
    if (s < 0) begin
      if (e.kind == KIND_FILL) begin
        if (m_fill_mode == OFM_MISSING) return STAT_MISSING;
        if (m_fill_mode != OFM_REDUCE) return STAT_ORPHAN;
        if (fq <= 0 || e.side == SIDE_UNKNOWN || e.side == SIDE_BAD) return STAT_ORPHAN;
        lv = find_price_level(e.side == SIDE_SELL, px);
        if (lv < 0) return STAT_ORPHAN;
        lv_vol[lv] -= fq;
        if (lv_vol[lv] <= 0) lv_used[lv] = 0;
        return STAT_REDUCED;
      end
      if (e.kind == KIND_MOVE) return STAT_MISSING;
      return m_cancel_ignore ? STAT_ORPHAN : STAT_MISSING;
    end
    sd = sl_side[s];
    if (e.kind == KIND_FILL) begin
      if (fq < 0) return STAT_MISMATCH;
      full = (sl_amt[s] <= fq);
      if (full) begin
        fq = sl_amt[s]; sl_used[s] = 0;
      end else sl_amt[s] -= fq;
      lv = find_price_level(sd, sl_price[s]);
      if (lv < 0) return STAT_NO_LEVEL;
      lv_vol[lv] -= fq;
      if (full && lv_orders[lv] > 0) lv_orders[lv]--;
      if (lv_vol[lv] <= 0) lv_used[lv] = 0;
      return STAT_APPLIED;
    end
    if (e.kind == KIND_MOVE) begin
      found = level_leave(sd, sl_price[s], sl_amt[s]);
      amt = (lft > 0) ? lft : sl_amt[s];
      lv = claim_level(sd, px);
      if (lv < 0) begin
        sl_used[s] = 0;
        return STAT_FULL;
      end
      level_join(lv, amt);
      sl_price[s] = px; sl_amt[s] = amt;
      return found ? STAT_APPLIED : STAT_NO_LEVEL;
    end
    // partial cancel
    if (e.kind == KIND_CANCEL && lft != 0) begin
      diff = sl_amt[s] - lft;
      st = STAT_APPLIED;
      if (diff < 0) return STAT_MISMATCH;
      lv = find_price_level(sd, sl_price[s]);
      if (lv < 0) st = STAT_NO_LEVEL;
      else begin
        lv_vol[lv] -= diff;
        if (lv_vol[lv] < 0) begin
          lv_vol[lv] = 0; st = STAT_CLAMPED;
        end
      end
      sl_amt[s] = lft;
      return st;
    end
    // full cancel or remove
    found = level_leave(sd, sl_price[s], sl_amt[s]);
    sl_used[s] = 0;
    return found ? STAT_APPLIED : STAT_NO_LEVEL;
  endfunction

  // status plus best bid and ask after the event
  function automatic book_top_t predict_book_top(book_event_t e);
    book_top_t r;
    bit bp, ap;
    longint bpx, apx, bq, aq;
    bp = 0; ap = 0; bpx = 0; apx = 0; bq = 0; aq = 0;
    r.status = apply_book_event(e);
    for (int i = 0; i < NSIDE; i++)
      if (lv_used[i] && (!bp || lv_price[i] > bpx)) begin
        bp = 1; bpx = lv_price[i]; bq = lv_vol[i];
      end
    for (int i = NSIDE; i < 2 * NSIDE; i++)
      if (lv_used[i] && (!ap || lv_price[i] < apx)) begin
        ap = 1; apx = lv_price[i]; aq = lv_vol[i];
      end
    if (bq < 0) bq = 0;
    if (aq < 0) aq = 0;
    r.bid_p = bp; r.bid_px = bpx[31:0]; r.bid_q = bq[39:0];
    r.ask_p = ap; r.ask_px = apx[31:0]; r.ask_q = aq[39:0];
    r.crossed = bp && ap && (bpx >= apx);
    return r;
  endfunction

  // event driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        book_expected.push_back(predict_book_top(cur_event));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (event_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_event = event_backlog.pop_front();
          s_axis_tvalid <= 1;
          s_axis_tdata <= {6'd0, cur_event.left, cur_event.total, cur_event.price,
                           cur_event.side, cur_event.key};
          s_axis_tuser <= {2'd0, cur_event.f_quote, cur_event.f_non_system,
                           cur_event.f_counter, cur_event.kind};
        end else begin
          s_axis_tvalid <= 0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    book_top_t got, want;
    if (rst) begin
      m_axis_tready <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tuser[3:0];
        got.bid_p = m_axis_tdata[0];
        got.bid_px = m_axis_tdata[32:1];
        got.bid_q = m_axis_tdata[72:33];
        got.ask_p = m_axis_tdata[73];
        got.ask_px = m_axis_tdata[105:74];
        got.ask_q = m_axis_tdata[145:106];
        got.crossed = m_axis_tdata[146];
        results_seen <= results_seen + 1;
        if (book_expected.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result word, status %0d", got.status);
        end else begin
          want = book_expected.pop_front();
          if (got.status !== want.status || got.bid_p !== want.bid_p ||
              got.bid_px !== want.bid_px || got.bid_q !== want.bid_q ||
              got.ask_p !== want.ask_p || got.ask_px !== want.ask_px ||
              got.ask_q !== want.ask_q || got.crossed !== want.crossed) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) begin
              $display("mismatch at result %0d", results_seen);
              $display("  exp st=%0d bid=%0b %0d q%0d ask=%0b %0d q%0d x=%0b",
                       want.status, want.bid_p, want.bid_px, want.bid_q,
                       want.ask_p, want.ask_px, want.ask_q, want.crossed);
              $display("  got st=%0d bid=%0b %0d q%0d ask=%0b %0d q%0d x=%0b",
                       got.status, got.bid_p, got.bid_px, got.bid_q,
                       got.ask_p, got.ask_px, got.ask_q, got.crossed);
            end
          end
        end
      end
      // one long hold-off so the block backs up into its input
      if (!hold_done && results_seen == 700) begin
        hold_done <= 1;
        hold_left <= 6000;
        m_axis_tready <= 0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_COUNTER_SKIP:    m_counter_skip = val[0];
      CFG_NON_SYSTEM_SKIP: m_nonsys_skip = val[0];
      CFG_QUOTE_SKIP:      m_quote_skip = val[0];
      CFG_ORPHAN_FILL:     m_fill_mode = val;
      CFG_ORPHAN_CANCEL:   m_cancel_ignore = val[0];
      CFG_FILL_DELTA:      m_fill_delta = val[0];
      default: ;
    endcase
  endtask

  task automatic set_registers(bit cs, bit ns, bit qs, logic [1:0] ofm, bit oci, bit fd);
    @(posedge clk);
    write_reg(CFG_COUNTER_SKIP, {1'b0, cs});
    write_reg(CFG_NON_SYSTEM_SKIP, {1'b0, ns});
    write_reg(CFG_QUOTE_SKIP, {1'b0, qs});
    write_reg(CFG_ORPHAN_FILL, ofm);
    write_reg(CFG_ORPHAN_CANCEL, {1'b0, oci});
    write_reg(CFG_FILL_DELTA, {1'b0, fd});
    cfg_valid <= 0;
  endtask

  function automatic book_event_t make_event(logic [2:0] k, logic [63:0] key, logic [1:0] sd,
                                             logic signed [31:0] px, logic [31:0] tot,
                                             logic [31:0] lft);
    book_event_t e;
    e.kind = k; e.key = key; e.side = sd; e.price = px; e.total = tot; e.left = lft;
    e.f_counter = 0; e.f_non_system = 0; e.f_quote = 0;
    return e;
  endfunction

  // mostly well-formed order flow on a narrow price band, the rest noise
  function automatic book_event_t random_event();
    book_event_t e;
    int r;
    logic [1:0] sd;
    if ($urandom_range(99) < 25) begin
      e.kind = $urandom_range(7); e.key = {$urandom, $urandom};
      e.side = $urandom_range(3); e.price = $urandom;
      e.total = $urandom; e.left = $urandom;
      e.f_counter = $urandom_range(1); e.f_non_system = $urandom_range(1);
      e.f_quote = $urandom_range(1);
      return e;
    end
    r = $urandom_range(99);
    sd = $urandom_range(1, 2);
    e = make_event(KIND_ADD, $urandom_range(255), sd, 0, 0, 0);
    if (r < 35) begin
      e.kind = KIND_ADD;
      e.left = ($urandom_range(49) == 0) ? 32'hFFFF_FFFF : $urandom_range(1, 200);
      e.total = e.left;
      if ($urandom_range(9) == 0) e.key = {$urandom, $urandom};
      live_keys.push_back(e.key);
      if (live_keys.size() > 200) void'(live_keys.pop_front());
    end else begin
      e.kind = (r < 55) ? KIND_FILL : (r < 65) ? KIND_MOVE : (r < 85) ? KIND_CANCEL :
               (r < 95) ? KIND_REMOVE : 3'($urandom_range(5, 7));
      if (live_keys.size() > 0 && $urandom_range(9) != 0)
        e.key = live_keys[$urandom_range(live_keys.size() - 1)];
      e.total = $urandom_range(0, 80);
      e.left = ($urandom_range(3) == 0) ? 0 : $urandom_range(0, 150);
    end
    e.price = (sd == SIDE_SELL) ? 1000 + $signed($urandom_range(40)) - 10
                                : 1000 - $signed($urandom_range(40)) + 10;
    e.f_counter = ($urandom_range(9) == 0);
    e.f_non_system = ($urandom_range(9) == 0);
    e.f_quote = ($urandom_range(9) == 0);
    return e;
  endfunction

  task automatic drain_phase();
    while (event_backlog.size() > 0 || s_axis_tvalid || book_expected.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // directed checks, then random phases under changing registers and idling
  initial begin
    book_event_t e;
    rst = 1;
    s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = '0;
    m_axis_tready = 0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    cycles = 0; mismatches = 0; results_seen = 0; hold_left = 0; hold_done = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    m_counter_skip = 0; m_nonsys_skip = 0; m_quote_skip = 0;
    m_fill_mode = OFM_MISSING; m_cancel_ignore = 0; m_fill_delta = 1;
    for (int i = 0; i < NSLOT; i++) sl_used[i] = 0;
    for (int i = 0; i < 2 * NSIDE; i++) lv_used[i] = 0;
    repeat (11) @(posedge clk);
    rst <= 0;

    set_registers(0, 0, 0, OFM_MISSING, 0, 1);
    event_backlog.push_back(make_event(KIND_ADD, 1, 2'd1, 100, 10, 10));
    event_backlog.push_back(make_event(KIND_ADD, 2, SIDE_SELL, 105, 20, 20));
    event_backlog.push_back(make_event(KIND_ADD, 3, 2'd1, 100, 0, 0));
    event_backlog.push_back(make_event(KIND_ADD, 4, SIDE_UNKNOWN, 100, 5, 5));
    event_backlog.push_back(make_event(KIND_ADD, 5, SIDE_BAD, 100, 5, 5));
    event_backlog.push_back(make_event(KIND_FILL, 1, 2'd1, 100, 4, 6));
    event_backlog.push_back(make_event(KIND_FILL, 1, 2'd1, 100, 0, 6));
    event_backlog.push_back(make_event(KIND_CANCEL, 2, SIDE_SELL, 105, 0, 15));
    event_backlog.push_back(make_event(KIND_CANCEL, 2, SIDE_SELL, 105, 0, 99));
    event_backlog.push_back(make_event(KIND_MOVE, 1, 2'd1, 103, 0, 0));
    event_backlog.push_back(make_event(KIND_FILL, 99, 2'd1, 103, 3, 0));
    event_backlog.push_back(make_event(KIND_CANCEL, 98, 2'd1, 103, 0, 0));
    event_backlog.push_back(make_event(KIND_MOVE, 97, 2'd1, 103, 0, 4));
    event_backlog.push_back(make_event(3'd5, 1, 2'd1, 0, 0, 0));
    event_backlog.push_back(make_event(3'd7, '1, SIDE_BAD, '1, '1, '1));
    event_backlog.push_back(make_event(KIND_ADD, '1, 2'd1, 32'sh8000_0000, 1, '1));
    event_backlog.push_back(make_event(KIND_ADD, 64'h8000_0000_0000_0000, SIDE_SELL,
                                       32'sh7FFF_FFFF, '1, '1));
    event_backlog.push_back(make_event(KIND_ADD, 6, 2'd1, 110, 7, 7));
    event_backlog.push_back(make_event(KIND_ADD, 6, 2'd1, 111, 8, 8));
    event_backlog.push_back(make_event(KIND_FILL, 6, 2'd1, 111, '1, 0));
    e = make_event(KIND_ADD, 7, 2'd1, 90, 3, 3);
    e.f_counter = 1; e.f_non_system = 1; e.f_quote = 1;
    event_backlog.push_back(e);
    event_backlog.push_back(make_event(KIND_REMOVE, 2, SIDE_SELL, 0, 0, 0));
    event_backlog.push_back(make_event(KIND_REMOVE, 1, 2'd1, 0, 0, 0));
    event_backlog.push_back(make_event(KIND_REMOVE, '1, 2'd1, 0, 0, 0));
    event_backlog.push_back(make_event(KIND_REMOVE, 7, 2'd1, 0, 0, 0));
    drain_phase();

    for (int ph = 1; ph <= 8; ph++) begin
      case (ph)
        1: set_registers(1, 1, 1, 2'd3, 1, 1);
        2: set_registers(0, 0, 0, OFM_MISSING, 0, 0);
        3: set_registers(0, 0, 0, OFM_REDUCE, 1, 1);
        4: set_registers(1, 0, 1, OFM_REDUCE, 0, 0);
        default: set_registers($urandom_range(1), $urandom_range(1), $urandom_range(1),
                               $urandom_range(3), $urandom_range(1), $urandom_range(1));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 63; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 63; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      // run the buy side out of free levels, then take those orders away
      if (ph == 3) begin
        for (int i = 0; i < 66; i++)
          event_backlog.push_back(make_event(KIND_ADD, 64'h1000 + i, 2'd1, 5000 + i, 1, 1));
        for (int i = 0; i < 66; i++)
          event_backlog.push_back(make_event(KIND_REMOVE, 64'h1000 + i, 2'd1, 0, 0, 0));
      end
      repeat ((ph == 3) ? 21 : 150) event_backlog.push_back(random_event());
      drain_phase();
    end

    $display("covered %0d result words over 9 register settings and 4 idling patterns",
             results_seen);
    $display("directed corner events, level table overflow and a long receiver hold-off");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
